FILE: hdl/fpt_pkg.sv
// Shared types, constants and helpers for the four-level page table manager.
package fpt_pkg;

    localparam int VA_W          = 48;
    localparam int PA_W          = 48;
    localparam int FRAME_W       = 36;
    localparam int OFFSET_W      = 12;
    localparam int IDX_W         = 9;
    localparam int ENTRIES       = 4096 / 8;
    localparam int FLAG_W        = 5;
    localparam int ENTRY_W       = FRAME_W + FLAG_W;
    localparam int POOL_PAGES_DEF = 64;
    localparam int APB_AW        = 4;
    localparam int APB_DW        = 64;

    // Entry flag bit positions
    localparam int F_PRESENT = 0;
    localparam int F_WRITE   = 1;
    localparam int F_USER    = 2;
    localparam int F_WT      = 3;
    localparam int F_CD      = 4;

    // Flags of an intermediate entry: present, writable, user
    localparam logic [FLAG_W-1:0] DIR_FLAGS = 5'b00111;

    // Register index, taken from paddr[3]
    localparam logic REG_TABLE_BASE = 1'b0;

    // Walk level codes; the leaf level follows the three directory levels
    localparam logic [1:0] LVL_TOP  = 2'd0;
    localparam logic [1:0] LVL_LAST = 2'd2;
    localparam logic [1:0] LVL_LEAF = 2'd3;

    typedef enum logic [1:0] {
        FUNC_TRANSLATE = 2'd0,
        FUNC_MAP       = 2'd1,
        FUNC_UNMAP     = 2'd2
    } func_t;

    typedef enum logic [1:0] {
        STAT_DONE       = 2'd0,
        STAT_NOT_MAPPED = 2'd1,
        STAT_POOL_FULL  = 2'd2
    } status_t;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_WALK,
        ST_LEAF,
        ST_RESP
    } state_t;

    typedef struct packed {
        logic [FRAME_W-1:0] frame;
        logic [FLAG_W-1:0]  flags;
    } entry_t;

    // Table index of a level: 47:39, 38:30, 29:21, leaf 20:12
    function automatic logic [IDX_W-1:0] va_index(input logic [VA_W-1:0] va,
                                                  input logic [1:0] lvl);
        logic [IDX_W-1:0] idx;
        begin
            case (lvl)
                2'd0:    idx = va[47:39];
                2'd1:    idx = va[38:30];
                2'd2:    idx = va[29:21];
                default: idx = va[20:12];
            endcase
            return idx;
        end
    endfunction

endpackage

FILE: hdl/fpt_if.sv
// Request and response channel interfaces of the page table manager.
interface fpt_req_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  func;
    logic [fpt_pkg::VA_W-1:0]    virtual_address;
    logic [fpt_pkg::PA_W-1:0]    physical_address;
    logic                        write_enable;
    logic                        user_access;
    logic                        write_through;
    logic                        cache_disable;

    modport source (
        output valid, func, virtual_address, physical_address,
               write_enable, user_access, write_through, cache_disable,
        input  ready
    );
    modport sink (
        input  valid, func, virtual_address, physical_address,
               write_enable, user_access, write_through, cache_disable,
        output ready
    );
endinterface

interface fpt_rsp_if;
    logic                        valid;
    logic                        ready;
    logic [1:0]                  status;
    logic [fpt_pkg::VA_W-1:0]    translated_address;

    modport source (
        output valid, status, translated_address,
        input  ready
    );
    modport sink (
        input  valid, status, translated_address,
        output ready
    );
endinterface

FILE: hdl/four_level_page_table_manager.sv
// Top level of the four-level page table manager: walk sequencer, pool, config port.
//
//  channel | dir | handshake                  | beat carries
//  --------+-----+----------------------------+--------------------------------------
//  req     | in  | valid/ready                | func, addresses, leaf option bits
//  rsp     | out | valid/ready                | status, translated_address
//  apb     | in  | psel/penable/pwrite, pready| table_base_frame at offset 0
//
//  Sequence: func 3 goes from accept straight to the result; translate, map and
//  unmap step through accept, up to three directory reads, leaf, result,
//  set by the single read port of the table RAM, one dependent read a cycle.
//  Reset: the RAM is swept to zero, req.ready low.
//  A result waits in the output register; the next request beat is taken
//  meanwhile, and the walk stalls in its result state while that is full.
module four_level_page_table_manager #(
    parameter int POOL_PAGES = fpt_pkg::POOL_PAGES_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    fpt_req_if.sink                       req,
    fpt_rsp_if.source                     rsp,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [fpt_pkg::APB_AW-1:0]    paddr,
    input  logic [fpt_pkg::APB_DW-1:0]    pwdata,
    output logic [fpt_pkg::APB_DW-1:0]    prdata,
    output logic                          pready
);

    import fpt_pkg::*;

    localparam int DEPTH  = POOL_PAGES * ENTRIES;
    localparam int ADDR_W = $clog2(DEPTH);
    localparam int PAGE_W = $clog2(POOL_PAGES);
    localparam int PU_W   = $clog2(POOL_PAGES + 1);

    // Control state
    state_t               state_reg, state_next;
    logic [ADDR_W-1:0]    clr_cnt_reg, clr_cnt_next;
    logic [PU_W-1:0]      pages_used_reg, pages_used_next;
    logic                 out_valid_reg, out_valid_next;
    logic [FRAME_W-1:0]   base_reg;

    // Per-item working registers
    logic [1:0]           func_reg, func_next;
    logic [VA_W-1:0]      va_reg, va_next;
    logic [FRAME_W-1:0]   pa_frame_reg, pa_frame_next;
    logic [3:0]           opt_reg, opt_next;
    logic [PAGE_W-1:0]    page_reg, page_next;
    logic [1:0]           lvl_reg, lvl_next;
    status_t              status_reg, status_next;
    logic [VA_W-1:0]      result_reg, result_next;
    status_t              out_status_reg, out_status_next;
    logic [VA_W-1:0]      out_addr_reg, out_addr_next;

    // Table RAM
    logic                 ram_we;
    logic [ADDR_W-1:0]    ram_waddr;
    logic [ENTRY_W-1:0]   ram_wdata;
    logic [ADDR_W-1:0]    ram_raddr;
    logic [ENTRY_W-1:0]   ram_rdata;

    // Walk datapath
    entry_t               ent;
    logic [FRAME_W-1:0]   rel;
    logic                 link_ok;
    logic                 pool_full;
    logic [FRAME_W-1:0]   alloc_frame;
    logic                 walk_ok;
    logic [PAGE_W-1:0]    page_go;
    logic                 cfg_wr;

    fpt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ------------------------------------------------------------------
    // Configuration port: one 64-bit slot, writes land in the access phase
    // ------------------------------------------------------------------
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_comb
    begin
        unique case (paddr[3])
            REG_TABLE_BASE: prdata = APB_DW'(base_reg);
            default:        prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Entry checks on the registered read data
    // ------------------------------------------------------------------
    assign ent         = entry_t'(ram_rdata);
    // Link target relative to pool page 0, modulo the frame width
    assign rel         = ent.frame - base_reg;
    assign link_ok     = rel < FRAME_W'(pages_used_reg);
    assign pool_full   = pages_used_reg == PU_W'(POOL_PAGES);
    assign alloc_frame = base_reg + FRAME_W'(pages_used_reg);

    // ------------------------------------------------------------------
    // Sequencer: next state, RAM control and working registers
    // ------------------------------------------------------------------
    always_comb
    begin
        state_next      = state_reg;
        clr_cnt_next    = clr_cnt_reg;
        pages_used_next = pages_used_reg;
        out_valid_next  = out_valid_reg;
        func_next       = func_reg;
        va_next         = va_reg;
        pa_frame_next   = pa_frame_reg;
        opt_next        = opt_reg;
        page_next       = page_reg;
        lvl_next        = lvl_reg;
        status_next     = status_reg;
        result_next     = result_reg;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;
        ram_we          = 1'b0;
        ram_waddr       = '0;
        ram_wdata       = '0;
        ram_raddr       = '0;
        walk_ok         = 1'b0;
        page_go         = page_reg;

        // Drop the output beat once taken; a new result may refill it below
        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_CLEAR:
            begin
                // Sweep the whole pool to zero, one entry a cycle
                ram_we       = 1'b1;
                ram_waddr    = clr_cnt_reg;
                clr_cnt_next = clr_cnt_reg + 1'b1;
                if (clr_cnt_reg == ADDR_W'(DEPTH - 1))
                begin
                    state_next = ST_IDLE;
                end
            end

            ST_IDLE:
            begin
                if (req.valid)
                begin
                    func_next     = req.func;
                    va_next       = req.virtual_address;
                    pa_frame_next = req.physical_address[PA_W-1:OFFSET_W];
                    opt_next      = {req.cache_disable, req.write_through,
                                     req.user_access, req.write_enable};
                    page_next     = '0;
                    lvl_next      = LVL_TOP;
                    status_next   = STAT_DONE;
                    result_next   = '0;
                    // Issue the root read right away
                    ram_raddr     = {PAGE_W'(0), va_index(req.virtual_address, LVL_TOP)};
                    if (req.func == FUNC_MAP || req.func == FUNC_UNMAP ||
                        req.func == FUNC_TRANSLATE)
                    begin
                        state_next = ST_WALK;
                    end
                    else
                    begin
                        state_next = ST_RESP;
                    end
                end
            end

            ST_WALK:
            begin
                if (func_reg == FUNC_MAP)
                begin
                    if (ent.flags[F_PRESENT])
                    begin
                        if (link_ok)
                        begin
                            walk_ok = 1'b1;
                            page_go = rel[PAGE_W-1:0];
                        end
                        else
                        begin
                            status_next = STAT_POOL_FULL;
                            state_next  = ST_RESP;
                        end
                    end
                    else if (pool_full)
                    begin
                        status_next = STAT_POOL_FULL;
                        state_next  = ST_RESP;
                    end
                    else
                    begin
                        // Hand out the next page; it is still zero from the sweep
                        ram_we          = 1'b1;
                        ram_waddr       = {page_reg, va_index(va_reg, lvl_reg)};
                        ram_wdata       = {alloc_frame, DIR_FLAGS};
                        pages_used_next = pages_used_reg + 1'b1;
                        page_go         = pages_used_reg[PAGE_W-1:0];
                        walk_ok         = 1'b1;
                    end
                end
                else
                begin
                    if (ent.flags[F_PRESENT] && link_ok)
                    begin
                        walk_ok = 1'b1;
                        page_go = rel[PAGE_W-1:0];
                    end
                    else
                    begin
                        status_next = STAT_NOT_MAPPED;
                        state_next  = ST_RESP;
                    end
                end

                if (walk_ok)
                begin
                    // Read the next level, or the leaf after the last directory
                    page_next = page_go;
                    ram_raddr = {page_go, va_index(va_reg, lvl_reg + 2'd1)};
                    lvl_next  = lvl_reg + 2'd1;
                    if (lvl_reg == LVL_LAST)
                    begin
                        state_next = ST_LEAF;
                    end
                end
            end

            ST_LEAF:
            begin
                ram_waddr  = {page_reg, va_index(va_reg, LVL_LEAF)};
                state_next = ST_RESP;
                case (func_reg)
                    FUNC_MAP:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {pa_frame_reg, opt_reg, 1'b1};
                    end
                    FUNC_UNMAP:
                    begin
                        ram_we    = 1'b1;
                        ram_wdata = {ent.frame, ent.flags[FLAG_W-1:1], 1'b0};
                    end
                    default:
                    begin
                        if (ent.flags[F_PRESENT])
                        begin
                            result_next = {ent.frame, va_reg[OFFSET_W-1:0]};
                        end
                        else
                        begin
                            status_next = STAT_NOT_MAPPED;
                        end
                    end
                endcase
            end

            ST_RESP:
            begin
                // Hold until the output register is free
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_addr_next   = result_reg;
                    state_next      = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_CLEAR;
            clr_cnt_reg    <= '0;
            pages_used_reg <= PU_W'(1);
            out_valid_reg  <= 1'b0;
            base_reg       <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            clr_cnt_reg    <= clr_cnt_next;
            pages_used_reg <= pages_used_next;
            out_valid_reg  <= out_valid_next;
            if (cfg_wr && paddr[3] == REG_TABLE_BASE)
            begin
                base_reg <= pwdata[FRAME_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        func_reg       <= func_next;
        va_reg         <= va_next;
        pa_frame_reg   <= pa_frame_next;
        opt_reg        <= opt_next;
        page_reg       <= page_next;
        lvl_reg        <= lvl_next;
        status_reg     <= status_next;
        result_reg     <= result_next;
        out_status_reg <= out_status_next;
        out_addr_reg   <= out_addr_next;
    end

    assign req.ready              = state_reg == ST_IDLE;
    assign rsp.valid              = out_valid_reg;
    assign rsp.status             = out_status_reg;
    assign rsp.translated_address = out_addr_reg;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    a_pages_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        pages_used_reg >= PU_W'(1) && pages_used_reg <= PU_W'(POOL_PAGES))
        else $error("pages_used outside pool");

    a_alloc_only_in_map: assert property (@(posedge clk) disable iff (!rst_n)
        (pages_used_reg != $past(pages_used_reg)) |->
            ($past(state_reg) == ST_WALK && $past(func_reg) == FUNC_MAP &&
             pages_used_reg == $past(pages_used_reg) + PU_W'(1)))
        else $error("page allocated outside a map walk");

    a_write_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        ram_we |-> (state_reg == ST_CLEAR || state_reg == ST_WALK ||
                    state_reg == ST_LEAF))
        else $error("table write outside sweep or walk");

    a_accept_starts_walk: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> (state_reg == ST_WALK || state_reg == ST_RESP))
        else $error("accepted request did not start");
`endif

endmodule

FILE: hdl/fpt_ram.sv
// Generic simple dual-port RAM with registered read data.
module fpt_ram #(
    parameter int WIDTH = fpt_pkg::ENTRY_W,
    parameter int DEPTH = fpt_pkg::POOL_PAGES_DEF * fpt_pkg::ENTRIES,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: tb/sv/tb_top.sv
// Self-checking testbench for the four-level page table manager.
module tb_top;

    import fpt_pkg::*;

    localparam int POOL           = POOL_PAGES_DEF;
    localparam int SETTLE_CYCLES  = 16;      // idle padding once every result is back, generous
    localparam int RSP_STALL_LEN  = 300;     // long receiver hold-off
    localparam int PHASE_ITEMS    = 120;
    localparam int MAX_REPORTS    = 10;
    localparam int CYCLE_LIMIT    = 400000;  // leaves room for the reset sweep as well

    localparam logic [1:0] FUNC_UNUSED = 2'd3;
    localparam logic [APB_AW-1:0] TABLE_BASE_ADDR = {REG_TABLE_BASE, 3'b000};

    typedef struct packed {
        logic [1:0]  status;
        logic [47:0] xlat;
    } walk_result_t;

    logic clk;
    logic rst_n;

    fpt_req_if req_ch ();
    fpt_rsp_if rsp_ch ();

    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [APB_AW-1:0] paddr;
    logic [APB_DW-1:0] pwdata;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    four_level_page_table_manager dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // ------------------------------------------------------------------
    // Shadow of the block: table pool, pages handed out, base frame.
    // Entry layout: 47:12 frame, 4:0 flags, everything else zero.
    // ------------------------------------------------------------------
    bit   [63:0] table_model [0:POOL*512-1];
    int          pages_taken = 1;
    logic [35:0] table_base = '0;

    walk_result_t results_due [$];
    int           bad_results = 0;

    // Stimulus knobs
    bit   steady_flow = 1'b0;      // no random idling on either side
    logic rsp_stalled;
    event rsp_stall_go;

    // Address space carved out for one random phase
    logic [26:0] region_prefix [4];
    logic [8:0]  leaf_choice [8];

    function automatic logic [47:0] rand48();
        return {16'($urandom()), $urandom()};
    endfunction

    function automatic logic [47:0] make_va(input logic [8:0] top, input logic [8:0] mid,
                                            input logic [8:0] low, input logic [8:0] leaf,
                                            input logic [11:0] offset);
        return {top, mid, low, leaf, offset};
    endfunction

    // Pool page that a present entry links to, or -1 when the link lies outside the pages handed out.
    function automatic int link_target(input logic [63:0] entry);
        logic [35:0] rel;
        int          page;
        rel = entry[47:12] - table_base;
        if (rel >= 36'(pages_taken) || rel >= 36'(POOL))
            page = -1;
        else
            page = int'(rel);
        return page;
    endfunction

    // Walk the shadow tables for one request beat, update them, and compute the result.
    function automatic void walk_tables(input logic [1:0] func, input logic [47:0] va,
                                        input logic [47:0] pa, input logic [3:0] opts,
                                        output logic [1:0] status, output logic [47:0] xlat);
        logic [8:0]  idx [3];
        logic [35:0] frame;
        logic [63:0] entry;
        int          page;
        int          next_page;
        int          slot_at;
        int          lvl;
        status = STAT_DONE;
        xlat   = '0;
        page   = 0;
        idx[0] = va[47:39];
        idx[1] = va[38:30];
        idx[2] = va[29:21];
        if (func == FUNC_MAP)
        begin
            for (lvl = 0; lvl < 3 && status == STAT_DONE; lvl++)
            begin
                slot_at = page * 512 + idx[lvl];
                entry   = table_model[slot_at];
                if (entry[F_PRESENT])
                begin
                    next_page = link_target(entry);
                    if (next_page < 0)
                        status = STAT_POOL_FULL;
                    else
                        page = next_page;
                end
                else if (pages_taken >= POOL)
                    status = STAT_POOL_FULL;
                else
                begin
                    // Hand out the next page, clear it, and link it in
                    next_page = pages_taken;
                    pages_taken++;
                    for (int k = 0; k < 512; k++)
                        table_model[next_page * 512 + k] = '0;
                    frame = table_base + 36'(next_page);
                    table_model[slot_at] = {16'h0, frame, 7'h0, DIR_FLAGS};
                    page = next_page;
                end
            end
            // Leaf carries {cd, wt, user, we} and present
            if (status == STAT_DONE)
                table_model[page * 512 + va[20:12]] = {16'h0, pa[47:12], 7'h0, opts, 1'b1};
        end
        else if (func == FUNC_TRANSLATE || func == FUNC_UNMAP)
        begin
            for (lvl = 0; lvl < 3 && status == STAT_DONE; lvl++)
            begin
                entry     = table_model[page * 512 + idx[lvl]];
                next_page = entry[F_PRESENT] ? link_target(entry) : -1;
                if (next_page < 0)
                    status = STAT_NOT_MAPPED;
                else
                    page = next_page;
            end
            if (status == STAT_DONE)
            begin
                slot_at = page * 512 + va[20:12];
                if (func == FUNC_UNMAP)
                    table_model[slot_at][F_PRESENT] = 1'b0;
                else if (table_model[slot_at][F_PRESENT])
                    xlat = {table_model[slot_at][47:12], va[11:0]};
                else
                    status = STAT_NOT_MAPPED;
            end
        end
    endfunction

    // ------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------

    // Offer one request beat, hold it until taken, then record what it should return.
    task automatic send_request(input logic [1:0] func, input logic [47:0] va,
                                input logic [47:0] pa, input logic [3:0] opts);
        logic [1:0]  exp_status;
        logic [47:0] exp_xlat;
        if (!steady_flow && $urandom_range(99) < 20)
        begin
            // Drop valid for a random gap
            req_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(99) < 40)
                @(posedge clk);
        end
        req_ch.valid            <= 1'b1;
        req_ch.func             <= func;
        req_ch.virtual_address  <= va;
        req_ch.physical_address <= pa;
        req_ch.write_enable     <= opts[0];
        req_ch.user_access      <= opts[1];
        req_ch.write_through    <= opts[2];
        req_ch.cache_disable    <= opts[3];
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        walk_tables(func, va, pa, opts, exp_status, exp_xlat);
        results_due.push_back({exp_status, exp_xlat});
    endtask

    // Stop offering, let every outstanding walk return, then let the block fall idle.
    task automatic settle_block();
        req_ch.valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // APB write of the base frame: setup cycle, then access until pready.
    task automatic write_table_base(input logic [35:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= TABLE_BASE_ADDR;
        pwdata  <= {28'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        table_base = value;
    endtask

    function automatic logic [8:0] fresh_root_slot(input logic [8:0] taken);
        logic [8:0] s;
        s = 9'($urandom());
        while (table_model[s][F_PRESENT] || s == taken)
            s = 9'($urandom());
        return s;
    endfunction

    // Lay out four regions under two unused root slots, sharing upper levels,
    // plus a small set of leaf slots so that translates mostly hit.
    function automatic void plan_regions();
        logic [8:0] top0;
        logic [8:0] top1;
        logic [8:0] mid0;
        top0 = fresh_root_slot(9'd0);
        top1 = fresh_root_slot(top0);
        mid0 = 9'($urandom());
        region_prefix[0] = {top0, mid0, 9'($urandom())};
        region_prefix[1] = {top0, mid0, 9'($urandom())};
        region_prefix[2] = {top0, mid0 ^ 9'h155, 9'($urandom())};
        region_prefix[3] = {top1, 9'($urandom()), 9'($urandom())};
        leaf_choice[0] = 9'd0;
        leaf_choice[1] = 9'h1FF;
        for (int k = 2; k < 8; k++)
            leaf_choice[k] = 9'($urandom());
    endfunction

    // One random beat aimed at the current regions; with noise, some land anywhere.
    task automatic send_random_walk(input bit with_noise);
        logic [1:0]  func;
        logic [47:0] va;
        int          roll;
        roll = $urandom_range(99);
        if (roll < 35)
            func = FUNC_MAP;
        else if (roll < 80)
            func = FUNC_TRANSLATE;
        else if (roll < 95)
            func = FUNC_UNMAP;
        else
            func = FUNC_UNUSED;
        va = {region_prefix[$urandom_range(3)], leaf_choice[$urandom_range(7)],
              12'($urandom())};
        // Keep noise away from map so that stray walks do not drain the pool
        if (with_noise && func != FUNC_MAP && $urandom_range(99) < 8)
            va = rand48();
        send_request(func, va, rand48(), 4'($urandom()));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Walks through an empty root, and the unused function code.
    task automatic test_empty_table();
        send_request(FUNC_TRANSLATE, 48'h0, 48'h0, 4'h0);
        send_request(FUNC_UNMAP, {48{1'b1}}, {48{1'b1}}, 4'hF);
        send_request(FUNC_UNUSED, {48{1'b1}}, {48{1'b1}}, 4'hF);
    endtask

    // Map at both ends of the address space, each option bit alone, and a remap.
    task automatic test_map_and_translate();
        send_request(FUNC_MAP, 48'h0, {48{1'b1}}, 4'hF);
        send_request(FUNC_TRANSLATE, 48'hFFF, 48'h0, 4'h0);
        send_request(FUNC_MAP, {48{1'b1}}, 48'h0, 4'h0);
        send_request(FUNC_TRANSLATE, {48{1'b1}}, 48'h0, 4'h0);
        for (int b = 0; b < 4; b++)
            send_request(FUNC_MAP, make_va(9'd0, 9'd0, 9'd0, 9'(b + 1), 12'h0), rand48(),
                         4'(1 << b));
        send_request(FUNC_TRANSLATE, make_va(9'd0, 9'd0, 9'd0, 9'd3, 12'h123), 48'h0, 4'h0);
        // Overwrite an existing leaf
        send_request(FUNC_MAP, 48'h0, rand48(), 4'h5);
        send_request(FUNC_TRANSLATE, 48'h0, 48'h0, 4'h0);
    endtask

    // Unmap a live leaf, a cleared leaf, and walks that miss at lower levels.
    task automatic test_unmap();
        send_request(FUNC_UNMAP, 48'h0, 48'h0, 4'h0);
        send_request(FUNC_TRANSLATE, 48'h0, 48'h0, 4'h0);
        send_request(FUNC_UNMAP, 48'h0, 48'h0, 4'h0);
        send_request(FUNC_UNMAP, make_va(9'd0, 9'd0, 9'd1, 9'd0, 12'h0), 48'h0, 4'h0);
        send_request(FUNC_TRANSLATE, make_va(9'd0, 9'd1, 9'd0, 9'd0, 12'h0), 48'h0, 4'h0);
    endtask

    // Base at its top value so new frames wrap, then a base that pushes
    // old links outside the pool: translate and unmap miss, map reports pool full.
    task automatic test_base_extremes();
        logic [47:0] va;
        va = make_va(9'd5, 9'd6, 9'd7, 9'd8, 12'hABC);
        settle_block();
        write_table_base({36{1'b1}});
        send_request(FUNC_MAP, va, rand48(), 4'hA);
        send_request(FUNC_TRANSLATE, va, 48'h0, 4'h0);
        send_request(FUNC_TRANSLATE, {48{1'b1}}, 48'h0, 4'h0);
        settle_block();
        write_table_base(36'h8_0000_0000);
        send_request(FUNC_TRANSLATE, {48{1'b1}}, 48'h0, 4'h0);
        send_request(FUNC_UNMAP, {48{1'b1}}, 48'h0, 4'h0);
        send_request(FUNC_MAP, {48{1'b1}}, rand48(), 4'hF);
    endtask

    // Random phases, each under its own base and fresh regions; one runs without idling.
    task automatic test_random_phases();
        logic [35:0] phase_base [4];
        phase_base[0] = {4'($urandom()), $urandom()};
        phase_base[1] = '0;
        phase_base[2] = {36{1'b1}};
        phase_base[3] = {4'($urandom()), $urandom()};
        for (int p = 0; p < 4; p++)
        begin
            settle_block();
            write_table_base(phase_base[p]);
            plan_regions();
            steady_flow = (p == 1);
            repeat (PHASE_ITEMS)
                send_random_walk(1'b1);
        end
        steady_flow = 1'b0;
    endtask

    // Hold the receiver off while beats keep coming, so the block fills and stalls.
    task automatic test_backpressure();
        -> rsp_stall_go;
        repeat (40)
            send_random_walk(1'b0);
    endtask

    // Pause the sender until every result has come back, then resume.
    task automatic test_drain_pause();
        settle_block();
        repeat (10)
            send_random_walk(1'b0);
    endtask

    // Map at random addresses until the pool runs out, then keep using what exists.
    task automatic test_pool_exhaustion();
        logic [47:0] va;
        repeat (30)
        begin
            va = rand48();
            send_request(FUNC_MAP, va, rand48(), 4'($urandom()));
            send_request(FUNC_TRANSLATE, va, 48'h0, 4'h0);
        end
        repeat (20)
            send_random_walk(1'b0);
    endtask

    // ------------------------------------------------------------------
    // Response side
    // ------------------------------------------------------------------

    task automatic check_result();
        walk_result_t due;
        if (results_due.size() == 0)
        begin
            bad_results++;
            if (bad_results <= MAX_REPORTS)
                $display("unexpected result beat: status %0d address %h",
                         rsp_ch.status, rsp_ch.translated_address);
        end
        else
        begin
            due = results_due.pop_front();
            if (rsp_ch.status !== due.status || rsp_ch.translated_address !== due.xlat)
            begin
                bad_results++;
                if (bad_results <= MAX_REPORTS)
                    $display("result mismatch: expected status %0d address %h, got %0d %h",
                             due.status, due.xlat, rsp_ch.status, rsp_ch.translated_address);
            end
        end
    endtask

    // Check each taken result beat, then pick ready for the next cycle.
    always @(posedge clk)
    begin
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
            check_result();
        if (rsp_stalled)
            rsp_ch.ready <= 1'b0;
        else
            rsp_ch.ready <= steady_flow || ($urandom_range(99) >= 20);
    end

    // Count out the long receiver hold-off on request
    initial
    begin
        rsp_stalled = 1'b0;
        forever
        begin
            @(rsp_stall_go);
            rsp_stalled <= 1'b1;
            repeat (RSP_STALL_LEN)
                @(posedge clk);
            rsp_stalled <= 1'b0;
        end
    end

    // ------------------------------------------------------------------
    // Clock, watchdog, main sequence
    // ------------------------------------------------------------------

    initial
    begin
        clk = 1'b0;
        forever
            #1 clk = ~clk;
    end

    // Abort a hung run
    initial
    begin
        int cycles;
        cycles = 0;
        while (cycles < CYCLE_LIMIT)
        begin
            @(posedge clk);
            cycles++;
        end
        $display("Verification failed");
        $finish;
    end

    initial
    begin
        rst_n                   = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.func             = FUNC_TRANSLATE;
        req_ch.virtual_address  = '0;
        req_ch.physical_address = '0;
        req_ch.write_enable     = 1'b0;
        req_ch.user_access      = 1'b0;
        req_ch.write_through    = 1'b0;
        req_ch.cache_disable    = 1'b0;
        rsp_ch.ready            = 1'b0;
        psel                    = 1'b0;
        penable                 = 1'b0;
        pwrite                  = 1'b0;
        paddr                   = '0;
        pwdata                  = '0;
        repeat (10)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // The block sweeps its table store after reset; the first beat waits on ready
        write_table_base('0);
        test_empty_table();
        test_map_and_translate();
        test_unmap();
        test_base_extremes();
        test_random_phases();
        test_backpressure();
        test_drain_pause();
        test_pool_exhaustion();

        settle_block();
        if (bad_results == 0 && results_due.size() == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

FILE: files.f
hdl/fpt_pkg.sv
hdl/fpt_if.sv
hdl/fpt_ram.sv
hdl/four_level_page_table_manager.sv
tb/sv/tb_top.sv
